[rtl/berint_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// berint_pkg
// Shared types and constants for the BER INTEGER content codec.
// ----------------------------------------------------------------------------
package berint_pkg;

    localparam int MAX_BYTES   = 8;
    localparam int ENC_BYTES   = 8;
    localparam int VALUE_W     = 64;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int IDX_W       = 3;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]         data;
        logic                      last;
        logic [COUNT_W-1:0]        count;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]         byte_val;
        logic                      last;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic                      overflow;
    } res_t;

endpackage
`default_nettype wire

[rtl/berint_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// berint_front
// Classifies an incoming transaction and finds the minimal byte count of an
// encode value.
// ----------------------------------------------------------------------------
module berint_front
(
    input  wire logic                               mode,
    input  wire logic signed [berint_pkg::VALUE_W-1:0] value_in,
    input  wire logic [berint_pkg::BYTE_W-1:0]      byte_in,
    input  wire logic                               last_in,
    output berint_pkg::cmd_t                        cmd
);

    logic [berint_pkg::VALUE_W-1:0] uval;
    logic [berint_pkg::VALUE_W-1:0] top;
    logic [berint_pkg::COUNT_W-1:0] nbytes;

    assign uval = value_in;

    always_comb
    begin
        nbytes = berint_pkg::COUNT_W'(berint_pkg::ENC_BYTES);
        top    = '0;
        for (int n = berint_pkg::ENC_BYTES - 1; n >= 1; n--)
        begin
            top = uval >> (8 * n - 1);
            if ((top == '0) || (top == ({berint_pkg::VALUE_W{1'b1}} >> (8 * n - 1))))
            begin
                nbytes = berint_pkg::COUNT_W'(n);
            end
        end
    end

    always_comb
    begin
        cmd.mode  = mode;
        cmd.value = value_in;
        cmd.data  = byte_in;
        cmd.last  = last_in;
        cmd.count = (mode == berint_pkg::MODE_ENCODE) ? nbytes : '0;
    end

endmodule
`default_nettype wire

[rtl/berint_cmdq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// berint_cmdq
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module berint_cmdq
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire berint_pkg::cmd_t wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output berint_pkg::cmd_t      rd_data,
    output logic                  q_empty
);

    berint_pkg::cmd_t                   mem [berint_pkg::CMDQ_DEPTH];
    logic [berint_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [berint_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [berint_pkg::CMDQ_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                               do_wr, do_rd;

    assign q_full  = (cnt_reg == berint_pkg::CMDQ_CNT_W'(berint_pkg::CMDQ_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == berint_pkg::CMDQ_PTR_W'(berint_pkg::CMDQ_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == berint_pkg::CMDQ_PTR_W'(berint_pkg::CMDQ_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

[rtl/berint_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// berint_back
// Executes queued commands: emits encode bytes one per cycle while the output
// register is free, accumulates decode bytes, and holds the current result there.
// ----------------------------------------------------------------------------
module berint_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire berint_pkg::cmd_t head,
    input  wire logic             head_valid,
    output logic                  head_pop,
    output berint_pkg::res_t      res,
    output logic                  res_empty,
    input  wire logic             res_pop
);

    logic [berint_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [berint_pkg::COUNT_W-1:0] seen_reg, seen_next;
    logic                           long_reg, long_next;
    logic [berint_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    berint_pkg::res_t               out_reg, out_next;

    logic [berint_pkg::VALUE_W-1:0] dec_acc;
    logic [berint_pkg::COUNT_W-1:0] dec_seen;
    logic                           dec_long;
    logic                           is_enc, out_free, fire, enc_last;
    logic [berint_pkg::IDX_W-1:0]   enc_sel;

    assign is_enc   = (head.mode == berint_pkg::MODE_ENCODE);
    assign out_free = !out_valid_reg || res_pop;
    assign enc_sel  = head.count[berint_pkg::IDX_W-1:0] - 1'b1 - idx_reg;
    assign enc_last = ({1'b0, idx_reg} == (head.count - 1'b1));
    assign fire     = head_valid && (is_enc ? out_free : (!head.last || out_free));
    assign head_pop = fire && (!is_enc || enc_last);

    always_comb
    begin
        dec_acc  = acc_reg;
        dec_seen = seen_reg;
        dec_long = long_reg;
        if (seen_reg == '0)
        begin
            dec_acc  = {{(berint_pkg::VALUE_W - berint_pkg::BYTE_W){head.data[7]}}, head.data};
            dec_seen = berint_pkg::COUNT_W'(1);
        end
        else if (seen_reg < berint_pkg::COUNT_W'(berint_pkg::MAX_BYTES))
        begin
            dec_acc  = {acc_reg[berint_pkg::VALUE_W-berint_pkg::BYTE_W-1:0], head.data};
            dec_seen = seen_reg + 1'b1;
        end
        else
        begin
            dec_long = 1'b1;
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        seen_next      = seen_reg;
        long_next      = long_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res_pop;
        out_next       = out_reg;
        if (fire)
        begin
            if (is_enc)
            begin
                out_valid_next    = 1'b1;
                out_next.byte_val = head.value[enc_sel * berint_pkg::BYTE_W +: berint_pkg::BYTE_W];
                out_next.last     = enc_last;
                out_next.value    = '0;
                out_next.count    = head.count;
                out_next.overflow = 1'b0;
                idx_next          = enc_last ? '0 : idx_reg + 1'b1;
            end
            else if (head.last)
            begin
                out_valid_next    = 1'b1;
                out_next.byte_val = '0;
                out_next.last     = 1'b1;
                out_next.value    = dec_acc;
                out_next.count    = dec_seen;
                out_next.overflow = dec_long;
                acc_next          = '0;
                seen_next         = '0;
                long_next         = 1'b0;
            end
            else
            begin
                acc_next  = dec_acc;
                seen_next = dec_seen;
                long_next = dec_long;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            seen_reg      <= '0;
            long_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            seen_reg      <= seen_next;
            long_reg      <= long_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res       = out_reg;
    assign res_empty = !out_valid_reg;

endmodule
`default_nettype wire

[rtl/ber_integer_content_codec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ber_integer_content_codec
// BER INTEGER content octet encoder and decoder, selected per transaction.
// ----------------------------------------------------------------------------
// Input side is a queue: present mode, value_in, byte_in, last_in with push;
// a transaction is taken when push is high and full is low. Mode 0 encodes
// value_in into 1 to 8 content bytes; mode 1 feeds one content byte.
// Result side is a queue: while empty is low the oldest result is on
// byte_out, last_out, value_out, byte_count and overflow; pop takes it.
// An encode yields one result per byte, most significant first, one byte per
// cycle while the output register is free; a decode byte marked last also
// waits for it, and only the byte marked last yields a result.
// The first result passes through the command queue and the output register.
// A two-entry command queue decouples the front from the back, so input is
// taken while the back emits; when pop stays low the output register holds,
// the back stalls on encode and final decode bytes, and full rises once the
// queue fills. Reset clears the queue, output valid flag and decode state.
// ----------------------------------------------------------------------------
module ber_integer_content_codec
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic                                  mode,
    input  wire logic signed [berint_pkg::VALUE_W-1:0] value_in,
    input  wire logic [berint_pkg::BYTE_W-1:0]         byte_in,
    input  wire logic                                  last_in,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic [berint_pkg::BYTE_W-1:0]              byte_out,
    output logic                                       last_out,
    output logic signed [berint_pkg::VALUE_W-1:0]      value_out,
    output logic [berint_pkg::COUNT_W-1:0]             byte_count,
    output logic                                       overflow
);

    berint_pkg::cmd_t front_cmd;
    berint_pkg::cmd_t head_cmd;
    berint_pkg::res_t res;
    logic             q_empty;
    logic             head_pop;

    berint_front u_front
    (
        .mode     (mode),
        .value_in (value_in),
        .byte_in  (byte_in),
        .last_in  (last_in),
        .cmd      (front_cmd)
    );

    berint_cmdq u_cmdq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .q_full  (full),
        .rd_en   (head_pop),
        .rd_data (head_cmd),
        .q_empty (q_empty)
    );

    berint_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_cmd),
        .head_valid (!q_empty),
        .head_pop   (head_pop),
        .res        (res),
        .res_empty  (empty),
        .res_pop    (pop)
    );

    assign byte_out   = res.byte_val;
    assign last_out   = res.last;
    assign value_out  = res.value;
    assign byte_count = res.count;
    assign overflow   = res.overflow;

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (byte_count != '0))
        else $error("result byte count is zero");

    a_mid_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_out) |-> ((value_out == '0) && !overflow))
        else $error("non-final encode byte carries decode fields");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflow) |->
            (byte_count == berint_pkg::COUNT_W'(berint_pkg::MAX_BYTES)))
        else $error("overflow without full byte count");

    a_value_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (value_out != '0)) |-> last_out)
        else $error("decoded value on non-final result");

endmodule
`default_nettype wire
